[rtl/core/bc_pkg.sv]
// shared widths and limits for the binomial coefficient core
package bc_pkg;
	localparam int MAX_N  = 255;
	localparam int N_W    = 8;
	localparam int K_W    = 8;
	localparam int COEF_W = 32;
	localparam int PROD_W = COEF_W + N_W;
	localparam int CNT_W  = $clog2(COEF_W);
endpackage

[rtl/core/bc_in_if.sv]
// request channel interface: n and k of one transaction
interface bc_in_if;
	import bc_pkg::*;
	logic           valid;
	logic           ready;
	logic [N_W-1:0] n_total;
	logic [K_W-1:0] k_chosen;
	modport source (output valid, output n_total, output k_chosen, input ready);
	modport sink (input valid, input n_total, input k_chosen, output ready);
endinterface

[rtl/core/bc_out_if.sv]
// result channel interface: coefficient and wrap flag of one transaction
interface bc_out_if;
	import bc_pkg::*;
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] coefficient;
	logic              wrapped;
	modport source (output valid, output coefficient, output wrapped, input ready);
	modport sink (input valid, input coefficient, input wrapped, output ready);
endinterface

[rtl/core/binomial_coefficient_core.sv]
// binomial coefficient core: C(n,k) by the multiplicative loop in 32-bit wrapping arithmetic
//
// Usage: a transaction on items carries n_total and k_chosen; one transaction on results
// returns coefficient and wrapped. k is first folded to min(k, n-k); k > n gives 0.
// Each loop step multiplies the running value by (n-i) with a bit-serial shift-add over
// the 8 bits of (n-i), then divides by (i+1) with a restoring divider, one quotient bit
// per cycle over the 32 bits of the product.
// The loop runs min(k, n-k) steps (at most 127) after the item is taken; k > n, k = 0 or
// k = n skip the loop and go straight to the done state.
// One item is worked at a time: items.ready is high only while idle.
// The finished result sits in an output register, so the next item is taken while
// a result still waits on a stalled receiver; if the receiver still stalls when the
// next result is done, the loop holds in its done state until the register frees.
// Reset (arst_n low, asynchronous) returns the loop to idle and drops results.valid.
module binomial_coefficient_core (
	input logic     clk,
	input logic     arst_n,
	bc_in_if.sink   items,
	bc_out_if.source results
);
	import bc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [N_W-1:0]      n_q;
	logic [K_W-1:0]      k_q;
	logic [K_W-1:0]      i_q;
	logic [COEF_W-1:0]   acc_q;
	logic [PROD_W-1:0]   prod_q;
	logic [N_W-1:0]      mult_q;
	logic [K_W-1:0]      rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                wrap_q;
	logic                out_valid_q;
	logic [COEF_W-1:0]   coef_q;
	logic                wrapped_q;

	logic                in_fire;
	logic                out_free;
	logic [PROD_W-1:0]   prod_nxt;
	logic [K_W:0]        divisor;
	logic [K_W:0]        trial;
	logic                q_bit;
	logic [K_W-1:0]      i_inc;
	logic [N_W-1:0]      n_minus_k;
	logic [K_W-1:0]      k_fold;
	logic                reject;

	assign in_fire   = items.valid && items.ready;
	assign out_free  = !out_valid_q || results.ready;
	assign items.ready = (state_q == ST_IDLE);

	assign n_minus_k = items.n_total - N_W'(items.k_chosen);
	assign reject    = (COEF_W'(items.n_total) > COEF_W'(MAX_N))
		|| (N_W'(items.k_chosen) > items.n_total);
	assign k_fold    = (N_W'(items.k_chosen) > n_minus_k) ? K_W'(n_minus_k) : items.k_chosen;

	// shift-add, most significant multiplier bit first
	assign prod_nxt = {prod_q[PROD_W-2:0], 1'b0}
		+ (mult_q[N_W-1] ? {{N_W{1'b0}}, acc_q} : {PROD_W{1'b0}});

	// restoring divide step: partial remainder with next dividend bit
	assign divisor = {1'b0, i_q} + (K_W+1)'(1);
	assign trial   = {rem_q, acc_q[COEF_W-1]};
	assign q_bit   = (trial >= divisor);
	assign i_inc   = i_q + K_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (reject || k_fold == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0 && i_inc == k_q) begin
						state_q <= ST_DONE;
					end else if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					n_q    <= items.n_total;
					k_q    <= k_fold;
					i_q    <= '0;
					wrap_q <= 1'b0;
					acc_q  <= reject ? '0 : COEF_W'(1);
					mult_q <= items.n_total;
					prod_q <= '0;
					cnt_q  <= CNT_W'(N_W - 1);
				end
			end
			ST_MUL: begin
				mult_q <= {mult_q[N_W-2:0], 1'b0};
				if (cnt_q == '0) begin
					acc_q  <= prod_nxt[COEF_W-1:0];
					wrap_q <= wrap_q | (|prod_nxt[PROD_W-1:COEF_W]);
					rem_q  <= '0;
					cnt_q  <= CNT_W'(COEF_W - 1);
				end else begin
					prod_q <= prod_nxt;
					cnt_q  <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIV: begin
				acc_q <= {acc_q[COEF_W-2:0], q_bit};
				rem_q <= q_bit ? K_W'(trial - divisor) : K_W'(trial);
				if (cnt_q == '0) begin
					i_q    <= i_inc;
					mult_q <= n_q - N_W'(i_inc);
					prod_q <= '0;
					cnt_q  <= CNT_W'(N_W - 1);
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					coef_q    <= acc_q;
					wrapped_q <= wrap_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid       = out_valid_q;
	assign results.coefficient = coef_q;
	assign results.wrapped     = wrapped_q;

	// partial remainder always stays below the divisor
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < divisor))
		else $error("partial remainder not below divisor");

	// loop index never reaches the folded k while stepping
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV) |-> (i_q < k_q))
		else $error("loop index out of range");

	// folded k is at most half of n
	a_k_folded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (N_W'(k_q) <= n_q - N_W'(k_q)))
		else $error("k not folded to min(k, n-k)");

	// k above n goes straight to done with a zero result
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (N_W'(items.k_chosen) > items.n_total))
		|=> (state_q == ST_DONE && acc_q == '0 && !wrap_q))
		else $error("k above n did not give zero");
endmodule

[test/testbench.sv]
// testbench for the binomial coefficient core: random handshakes checked against a predictor
`timescale 1ns / 100ps

module testbench;
	import bc_pkg::*;

	localparam int IDLE_LIMIT  = 25000;
	localparam int RAND_ITEMS  = 110;
	localparam int TAIL_CYCLES = 60;

	typedef struct {
		logic [N_W-1:0] n;
		logic [K_W-1:0] k;
		int unsigned    gap;
		bit             drain;
	} req_t;

	typedef struct {
		logic [COEF_W-1:0] coefficient;
		logic              wrapped;
	} coef_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bc_in_if  items_if ();
	bc_out_if results_if ();

	logic           drv_valid = 1'b0;
	logic [N_W-1:0] drv_n = '0;
	logic [K_W-1:0] drv_k = '0;
	logic           drv_rdy = 1'b0;

	assign items_if.valid    = drv_valid;
	assign items_if.n_total  = drv_n;
	assign items_if.k_chosen = drv_k;
	assign results_if.ready  = drv_rdy;

	binomial_coefficient_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	req_t  pending_q[$];
	coef_t coef_q[$];
	int    total_items = 0;
	int    sent_count = 0;
	int    got_count = 0;
	int    wrap_count = 0;
	int    zero_count = 0;
	int    errors = 0;
	int    idle_cycles = 0;
	bit    in_taken = 1'b0;
	bit    out_taken = 1'b0;

	// C(n,k) by the multiplicative loop, 32-bit wrapping product then truncating divide
	function automatic coef_t binom_wrap(input logic [N_W-1:0] n, input logic [K_W-1:0] k);
		coef_t             r;
		logic [COEF_W-1:0] run;
		logic [PROD_W-1:0] prod;
		int unsigned       steps;
		r.coefficient = '0;
		r.wrapped = 1'b0;
		if (int'(n) > MAX_N || k > n)
			return r;
		steps = 32'(k);
		if (steps > n - steps)
			steps = n - steps;
		run = COEF_W'(1);
		for (int unsigned i = 0; i < steps; i++) begin
			prod = PROD_W'(run) * PROD_W'(n - i);
			if (prod[PROD_W-1:COEF_W] != '0)
				r.wrapped = 1'b1;
			run = prod[COEF_W-1:0] / COEF_W'(i + 1);
		end
		r.coefficient = run;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch on result %0d: %s got %0h expected %0h", got_count, what, got, want);
		errors++;
	endtask

	task automatic add_item(input int unsigned n, input int unsigned k, input int unsigned gap,
			input bit drain);
		req_t r;
		r.n = N_W'(n);
		r.k = K_W'(k);
		r.gap = gap;
		r.drain = drain;
		pending_q.insert(pending_q.size(), r);
		total_items++;
	endtask

	// acceptance on both channels, checking and watchdog, all at the rising edge
	always @(posedge clk) begin
		coef_t want;
		bit    moved;
		moved = 1'b0;
		if (arst_n) begin
			in_taken <= items_if.valid && items_if.ready;
			out_taken <= results_if.valid && results_if.ready;
			if (items_if.valid && items_if.ready) begin
				coef_q.insert(coef_q.size(), binom_wrap(items_if.n_total, items_if.k_chosen));
				sent_count++;
				moved = 1'b1;
			end
			if (results_if.valid && results_if.ready) begin
				moved = 1'b1;
				if (coef_q.size() == 0) begin
					$display("result transaction with nothing outstanding: coefficient %0h",
						results_if.coefficient);
					errors++;
				end else begin
					want = coef_q.pop_front();
					if (results_if.coefficient !== want.coefficient)
						report_mismatch("coefficient", results_if.coefficient, want.coefficient);
					if (results_if.wrapped !== want.wrapped)
						report_mismatch("wrapped", results_if.wrapped, want.wrapped);
					if (want.wrapped)
						wrap_count++;
					if (want.coefficient == '0)
						zero_count++;
				end
				got_count++;
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// item driver
	bit          staged = 1'b0;
	req_t        staged_item;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		bit nxt_valid;
		if (arst_n && !(drv_valid && !in_taken)) begin
			nxt_valid = 1'b0;
			if (!staged && pending_q.size() > 0) begin
				if (!pending_q[0].drain || coef_q.size() == 0) begin
					staged_item = pending_q.pop_front();
					gap_left = staged_item.gap;
					staged = 1'b1;
				end
			end
			if (staged) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					nxt_valid = 1'b1;
					drv_n <= staged_item.n;
					drv_k <= staged_item.k;
					staged = 1'b0;
				end
			end
			drv_valid <= nxt_valid;
		end
	end

	// result receiver: a stall drawn per result, with runs of no stall
	bit          rx_armed = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;

	always @(negedge clk) begin
		bit nxt_rdy;
		if (arst_n && !(drv_rdy && !out_taken)) begin
			if (!rx_armed) begin
				if (rx_calm > 0) begin
					rx_calm--;
					rx_wait = 0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_calm = $urandom_range(5, 15);
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(0, 13);
				end
				rx_armed = 1'b1;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				nxt_rdy = 1'b0;
			end else begin
				nxt_rdy = 1'b1;
				rx_armed = 1'b0;
			end
			drv_rdy <= nxt_rdy;
		end
	end

	initial begin
		int unsigned n;
		int unsigned k;
		int unsigned j;
		int unsigned sel;
		int unsigned gap;

		// field extremes, folding, k above n, longest loop
		add_item(0, 0, $urandom_range(0, 13), 1'b0);
		add_item(255, 0, $urandom_range(0, 13), 1'b0);
		add_item(255, 255, $urandom_range(0, 13), 1'b0);
		add_item(0, 255, $urandom_range(0, 13), 1'b0);
		add_item(200, 201, $urandom_range(0, 13), 1'b0);
		add_item(85, 170, $urandom_range(0, 13), 1'b0);
		add_item(1, 1, $urandom_range(0, 13), 1'b0);
		add_item(1, 0, $urandom_range(0, 13), 1'b0);
		add_item(255, 1, $urandom_range(0, 13), 1'b0);
		add_item(255, 254, $urandom_range(0, 13), 1'b0);
		add_item(255, 127, $urandom_range(0, 13), 1'b0);
		add_item(255, 128, $urandom_range(0, 13), 1'b0);
		add_item(170, 85, $urandom_range(0, 13), 1'b0);
		add_item(128, 64, $urandom_range(0, 13), 1'b0);
		add_item(20, 10, $urandom_range(0, 13), 1'b0);
		add_item(30, 15, $urandom_range(0, 13), 1'b0);
		add_item(34, 17, $urandom_range(0, 13), 1'b0);
		add_item(67, 33, $urandom_range(0, 13), 1'b0);
		add_item(100, 3, $urandom_range(0, 13), 1'b0);
		add_item(100, 97, $urandom_range(0, 13), 1'b0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// a stretch of back-to-back items in the middle
			gap = (i >= 30 && i < 50) ? 0 : $urandom_range(0, 13);
			sel = $urandom_range(0, 99);
			n = $urandom_range(0, 255);
			if (sel < 55) begin
				// short loops: k or n-k small
				j = $urandom_range(0, 6);
				if (j > n)
					j = n;
				k = $urandom_range(0, 1) ? j : n - j;
			end else if (sel < 75) begin
				n = $urandom_range(0, 254);
				k = $urandom_range(n + 1, 255);
			end else if (sel < 90) begin
				n = $urandom_range(0, 40);
				k = $urandom_range(0, n);
			end else begin
				k = $urandom_range(0, 255);
			end
			add_item(n, k, gap, i == 0 || i == 65);
		end

		repeat (5) @(posedge clk);
		#1 arst_n = 1'b1;

		while (sent_count < total_items || coef_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items sent, %0d results checked: %0d wrapped, %0d zero coefficients",
			sent_count, got_count, wrap_count, zero_count);
		$display("random stalls on both channels, two drain pauses, one back-to-back stretch");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
